@@ rtl/cthd_pkg.sv @@
// Shared constants, widths, the atan table and the pipeline sideband type
// for the tilt-compensated compass heading unit. No dependencies.
package cthd_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STAGES   = 16;
    localparam int CORDIC_N        = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    localparam int UNIT_ONE  = 16384;
    localparam int SQW       = 30;      // square root remainder / root width
    localparam int SQ_STEPS  = 15;      // root digits of a 29-bit radicand
    localparam int QW        = 15;      // quotient / remainder width of the divider
    localparam int DIV_STEPS = 15;
    localparam int CW        = 50;      // CORDIC x/y width
    localparam int ZW        = 27;      // CORDIC angle accumulator, degrees in Q16
    localparam int HW        = 15;      // heading output width
    localparam int RND_SH    = 16 - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360 * 65536);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] RND_HALF  = ZW'(1 << (RND_SH - 1));
    localparam logic signed [ZW-1:0] TURN_OUT  = ZW'(360 << ANGLE_FRAC_BITS);
    localparam logic [SQW-1:0]       UNIT_SQ   = SQW'(1 << 28);

    // round(atan(2^-i) in degrees * 2^16)
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = ZW'(2949120);
            1:       a = ZW'(1740967);
            2:       a = ZW'(919879);
            3:       a = ZW'(466945);
            4:       a = ZW'(234379);
            5:       a = ZW'(117304);
            6:       a = ZW'(58666);
            7:       a = ZW'(29335);
            8:       a = ZW'(14668);
            9:       a = ZW'(7334);
            10:      a = ZW'(3667);
            11:      a = ZW'(1833);
            12:      a = ZW'(917);
            13:      a = ZW'(458);
            14:      a = ZW'(229);
            15:      a = ZW'(115);
            16:      a = ZW'(57);
            17:      a = ZW'(29);
            18:      a = ZW'(14);
            19:      a = ZW'(7);
            20:      a = ZW'(4);
            21:      a = ZW'(2);
            22:      a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Per-beat sideband carried down the pipeline next to the cell chains
    typedef struct packed {
        logic               vld;
        logic               clip;
        logic               big;    // |ay| above cos(pitch)
        logic               cz;     // cos(pitch) is zero
        logic               zp;     // plain vector is zero
        logic               zt;     // horizontal vector is zero
        logic signed [15:0] ay;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic signed [15:0] sp;
        logic [14:0]        cp;
        logic signed [15:0] sr;
        logic [14:0]        cr;
    } t_side;

endpackage

@@ rtl/cthd_sqrt_cell.sv @@
// One digit step of the restoring integer square root.
// Depends on cthd_pkg.
module cthd_sqrt_cell (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [cthd_pkg::SQW-1:0] i_bit,
    input  logic [cthd_pkg::SQW-1:0] i_rem,
    input  logic [cthd_pkg::SQW-1:0] i_root,
    output logic [cthd_pkg::SQW-1:0] o_rem,
    output logic [cthd_pkg::SQW-1:0] o_root
);
    import cthd_pkg::*;

    logic [SQW-1:0] w_trial;
    logic [SQW-1:0] n_rem;
    logic [SQW-1:0] n_root;
    logic [SQW-1:0] r_rem;
    logic [SQW-1:0] r_root;

    always_comb begin
        w_trial = i_root + i_bit;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + i_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ rtl/cthd_div_cell.sv @@
// One quotient bit of the restoring divider used for sin(roll).
// Depends on cthd_pkg.
module cthd_div_cell (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [cthd_pkg::QW-1:0] i_den,
    input  logic [cthd_pkg::QW-1:0] i_rem,
    input  logic [cthd_pkg::QW-1:0] i_num,
    input  logic [cthd_pkg::QW-1:0] i_quo,
    output logic [cthd_pkg::QW-1:0] o_rem,
    output logic [cthd_pkg::QW-1:0] o_num,
    output logic [cthd_pkg::QW-1:0] o_quo
);
    import cthd_pkg::*;

    logic [QW:0]   w_trial;
    logic [QW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [QW-1:0] r_rem;
    logic [QW-1:0] r_num;
    logic [QW-1:0] r_quo;

    always_comb begin
        w_trial = {i_rem, i_num[QW-1]};
        if (w_trial >= {1'b0, i_den}) begin
            n_rem = QW'(w_trial - {1'b0, i_den});
            n_quo = {i_quo[QW-2:0], 1'b1};
        end else begin
            n_rem = w_trial[QW-1:0];
            n_quo = {i_quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= {i_num[QW-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

@@ rtl/cthd_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation: drive y toward zero, sum the angle.
// Depends on cthd_pkg.
module cthd_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [4:0]                    i_shift,
    input  logic signed [cthd_pkg::ZW-1:0] i_angle,
    input  logic signed [cthd_pkg::CW-1:0] i_x,
    input  logic signed [cthd_pkg::CW-1:0] i_y,
    input  logic signed [cthd_pkg::ZW-1:0] i_z,
    output logic signed [cthd_pkg::CW-1:0] o_x,
    output logic signed [cthd_pkg::CW-1:0] o_y,
    output logic signed [cthd_pkg::ZW-1:0] o_z
);
    import cthd_pkg::*;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    always_comb begin
        w_dx = i_y >>> i_shift;
        w_dy = i_x >>> i_shift;
        if (i_y < 0) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - i_angle;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

@@ rtl/tilt_compensated_compass_heading_unit.sv @@
// Top level: tilt-compensated compass heading pipeline.
// Depends on cthd_pkg, cthd_sqrt_cell, cthd_div_cell, cthd_cordic_cell.
//
// channel | dir | tdata fields (lsb first)                        | tuser
// s_axis  | in  | accel_x, accel_y, mag_x, mag_y, mag_z (16b each)   | -
// m_axis  | out | heading_deg 15b, tilt_heading_deg 15b, tilt_clipped | -
//
// One beat per cycle while the output is not stalled. The pipeline holds
// two 15-cell square root chains, a 15-cell divider and the CORDIC rows.
// All stages advance together; they hold only while the output beat waits
// unaccepted, and s_axis_tready falls for exactly those cycles.
// Synchronous active-low reset clears the stage valid bits only.
module tilt_compensated_compass_heading_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // accel_x, accel_y, mag_x, mag_y, mag_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // heading_deg, tilt_heading_deg, tilt_clipped, pad
);
    import cthd_pkg::*;

    logic w_en;

    // input stage and radicand of cos(pitch)
    t_side                  r_s0, n_s0, r_s1;
    logic [SQW-1:0]         r_v1;
    logic signed [31:0]     w_sq1;

    // cos(pitch) root chain
    t_side                  side_a [0:SQ_STEPS];
    logic [SQW-1:0]         rem_a  [0:SQ_STEPS];
    logic [SQW-1:0]         root_a [0:SQ_STEPS];
    t_side                  r_s2, n_s2;

    // sin(roll) divider
    t_side                  side_d [0:DIV_STEPS];
    logic [QW-1:0]          rem_d  [0:DIV_STEPS];
    logic [QW-1:0]          num_d  [0:DIV_STEPS];
    logic [QW-1:0]          quo_d  [0:DIV_STEPS];
    t_side                  n_d0;
    logic [15:0]            w_mag;
    logic [SQW-1:0]         w_num;
    t_side                  r_s4, n_s4, r_s5;
    logic [QW-1:0]          w_q;
    logic [15:0]            w_srm;
    logic [SQW-1:0]         r_v5;
    logic signed [31:0]     w_sq5;

    // cos(roll) root chain
    t_side                  side_b [0:SQ_STEPS];
    logic [SQW-1:0]         rem_b  [0:SQ_STEPS];
    logic [SQW-1:0]         root_b [0:SQ_STEPS];
    t_side                  r_s6, n_s6;

    // products
    t_side                  r_p1, r_p2, r_p3;
    logic signed [31:0]     r_a, r_b, r_c, r_d, r_e, r_d2;
    logic signed [47:0]     r_cs, r_ec;
    logic signed [32:0]     r_ab;
    logic signed [CW-1:0]   r_xh, r_yh, r_xp, r_yp;

    // CORDIC rows
    t_side                  side_c [0:CORDIC_N];
    t_side                  n_c0;
    logic signed [CW-1:0]   xp_c [0:CORDIC_N];
    logic signed [CW-1:0]   yp_c [0:CORDIC_N];
    logic signed [ZW-1:0]   zp_c [0:CORDIC_N];
    logic signed [CW-1:0]   xt_c [0:CORDIC_N];
    logic signed [CW-1:0]   yt_c [0:CORDIC_N];
    logic signed [ZW-1:0]   zt_c [0:CORDIC_N];

    // output register
    logic                   r_ovld;
    logic [HW-1:0]          r_head, r_tilt;
    logic                   r_oclip;

    function automatic logic [HW-1:0] finish_angle(input logic signed [ZW-1:0] z,
                                                   input logic zero);
        logic signed [ZW-1:0] zw;
        logic signed [ZW-1:0] zr;
        zw = z;
        if (zw < 0) begin
            zw = zw + FULL_TURN;
        end
        if (zw >= FULL_TURN) begin
            zw = zw - FULL_TURN;
        end
        zr = (zw + RND_HALF) >>> RND_SH;
        if (zr >= TURN_OUT || zero) begin
            zr = '0;
        end
        return zr[HW-1:0];
    endfunction

    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---- clamp sin(pitch) = -ax
    always_comb begin
        logic signed [16:0] nax;
        nax        = -17'($signed(s_axis_tdata[15:0]));
        n_s0       = '0;
        n_s0.vld   = s_axis_tvalid;
        n_s0.ay    = $signed(s_axis_tdata[31:16]);
        n_s0.mx    = $signed(s_axis_tdata[47:32]);
        n_s0.my    = $signed(s_axis_tdata[63:48]);
        n_s0.mz    = $signed(s_axis_tdata[79:64]);
        if (nax > 17'sd16384) begin
            n_s0.sp   = 16'sd16384;
            n_s0.clip = 1'b1;
        end else if (nax < -17'sd16384) begin
            n_s0.sp   = -16'sd16384;
            n_s0.clip = 1'b1;
        end else begin
            n_s0.sp   = 16'(nax);
        end
    end

    assign w_sq1 = r_s0.sp * r_s0.sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
            r_s1.vld <= 1'b0;
        end else if (w_en) begin
            r_s0 <= n_s0;
            r_s1 <= r_s0;
            r_v1 <= UNIT_SQ - SQW'(w_sq1);
        end
    end

    // ---- cos(pitch) root
    assign side_a[0] = r_s1;
    assign rem_a[0]  = r_v1;
    assign root_a[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqa
        cthd_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_bit  (SQW'(1) << (2 * (SQ_STEPS - 1 - k))),
            .i_rem  (rem_a[k]),
            .i_root (root_a[k]),
            .o_rem  (rem_a[k+1]),
            .o_root (root_a[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                side_a[k+1].vld <= 1'b0;
            end else if (w_en) begin
                side_a[k+1] <= side_a[k];
            end
        end
    end

    // ---- round cos(pitch), set up the roll division
    assign w_mag = r_s2.ay[15] ? 16'(-17'(r_s2.ay)) : 16'(r_s2.ay);
    assign w_num = {w_mag, 14'b0} + SQW'(r_s2.cp >> 1);

    always_comb begin
        n_s2    = side_a[SQ_STEPS];
        n_s2.cp = root_a[SQ_STEPS][14:0] +
                  15'(rem_a[SQ_STEPS] > root_a[SQ_STEPS]);
    end

    always_comb begin
        n_d0     = r_s2;
        n_d0.big = w_mag > {1'b0, r_s2.cp};
        n_d0.cz  = (r_s2.cp == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld      <= 1'b0;
            side_d[0].vld <= 1'b0;
        end else if (w_en) begin
            r_s2      <= n_s2;
            side_d[0] <= n_d0;
            rem_d[0]  <= w_num[SQW-1:QW];
            num_d[0]  <= w_num[QW-1:0];
        end
    end

    assign quo_d[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        cthd_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (side_d[k].cp),
            .i_rem (rem_d[k]),
            .i_num (num_d[k]),
            .i_quo (quo_d[k]),
            .o_rem (rem_d[k+1]),
            .o_num (num_d[k+1]),
            .o_quo (quo_d[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                side_d[k+1].vld <= 1'b0;
            end else if (w_en) begin
                side_d[k+1] <= side_d[k];
            end
        end
    end

    // ---- finish sin(roll): saturate, special cases, sign of ay
    assign w_q = quo_d[DIV_STEPS];

    always_comb begin
        n_s4 = side_d[DIV_STEPS];
        if (n_s4.big) begin
            w_srm     = 16'd16384;
            n_s4.clip = 1'b1;
        end else if (n_s4.cz) begin
            w_srm = '0;
        end else if (w_q > 15'd16384) begin
            w_srm = 16'd16384;
        end else begin
            w_srm = {1'b0, w_q};
        end
        n_s4.sr = n_s4.ay[15] ? -$signed(w_srm) : $signed(w_srm);
    end

    assign w_sq5 = r_s4.sr * r_s4.sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
            r_s5.vld <= 1'b0;
        end else if (w_en) begin
            r_s4 <= n_s4;
            r_s5 <= r_s4;
            r_v5 <= UNIT_SQ - SQW'(w_sq5);
        end
    end

    // ---- cos(roll) root
    assign side_b[0] = r_s5;
    assign rem_b[0]  = r_v5;
    assign root_b[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqb
        cthd_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_bit  (SQW'(1) << (2 * (SQ_STEPS - 1 - k))),
            .i_rem  (rem_b[k]),
            .i_root (root_b[k]),
            .o_rem  (rem_b[k+1]),
            .o_root (root_b[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                side_b[k+1].vld <= 1'b0;
            end else if (w_en) begin
                side_b[k+1] <= side_b[k];
            end
        end
    end

    // ---- rotate the field into the horizontal plane
    always_comb begin
        n_s6    = side_b[SQ_STEPS];
        n_s6.cr = root_b[SQ_STEPS][14:0] +
                  15'(rem_b[SQ_STEPS] > root_b[SQ_STEPS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.vld <= 1'b0;
            r_p1.vld <= 1'b0;
            r_p2.vld <= 1'b0;
            r_p3.vld <= 1'b0;
        end else if (w_en) begin
            r_s6 <= n_s6;
            r_p1 <= r_s6;
            r_a  <= r_s6.mx * $signed({1'b0, r_s6.cp});
            r_b  <= r_s6.mz * r_s6.sp;
            r_c  <= r_s6.mx * r_s6.sr;
            r_d  <= r_s6.my * $signed({1'b0, r_s6.cr});
            r_e  <= r_s6.mz * r_s6.sr;
            r_p2 <= r_p1;
            r_ab <= 33'(r_a) + 33'(r_b);
            r_cs <= r_c * r_p1.sp;
            r_ec <= r_e * $signed({1'b0, r_p1.cp});
            r_d2 <= r_d;
            r_p3 <= r_p2;
            r_xh <= CW'(r_ab) <<< 14;
            r_yh <= CW'(r_cs) + (CW'(r_d2) <<< 14) - CW'(r_ec);
            r_xp <= CW'(r_p2.mx) <<< 24;
            r_yp <= CW'(r_p2.my) <<< 24;
        end
    end

    // ---- fold the left half plane into the right, seed the angle
    always_comb begin
        n_c0    = r_p3;
        n_c0.zp = (r_xp == '0) && (r_yp == '0);
        n_c0.zt = (r_xh == '0) && (r_yh == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_c[0].vld <= 1'b0;
        end else if (w_en) begin
            side_c[0] <= n_c0;
            if (r_xp < 0) begin
                xp_c[0] <= -r_xp;
                yp_c[0] <= -r_yp;
                zp_c[0] <= HALF_TURN;
            end else begin
                xp_c[0] <= r_xp;
                yp_c[0] <= r_yp;
                zp_c[0] <= '0;
            end
            if (r_xh < 0) begin
                xt_c[0] <= -r_xh;
                yt_c[0] <= -r_yh;
                zt_c[0] <= HALF_TURN;
            end else begin
                xt_c[0] <= r_xh;
                yt_c[0] <= r_yh;
                zt_c[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_cor
        cthd_cordic_cell u_plain (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_shift (5'(k)),
            .i_angle (atan_q16(k)),
            .i_x     (xp_c[k]),
            .i_y     (yp_c[k]),
            .i_z     (zp_c[k]),
            .o_x     (xp_c[k+1]),
            .o_y     (yp_c[k+1]),
            .o_z     (zp_c[k+1])
        );
        cthd_cordic_cell u_tilt (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_shift (5'(k)),
            .i_angle (atan_q16(k)),
            .i_x     (xt_c[k]),
            .i_y     (yt_c[k]),
            .i_z     (zt_c[k]),
            .o_x     (xt_c[k+1]),
            .o_y     (yt_c[k+1]),
            .o_z     (zt_c[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                side_c[k+1].vld <= 1'b0;
            end else if (w_en) begin
                side_c[k+1] <= side_c[k];
            end
        end
    end

    // ---- wrap, round, hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld  <= side_c[CORDIC_N].vld;
            r_head  <= finish_angle(zp_c[CORDIC_N], side_c[CORDIC_N].zp);
            r_tilt  <= finish_angle(zt_c[CORDIC_N], side_c[CORDIC_N].zt);
            r_oclip <= side_c[CORDIC_N].clip;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_oclip, r_tilt, r_head};

endmodule

@@ rtl/cthd_checker.sv @@
// Port-level checks for the compass heading unit, bound to the top level.
// Depends on cthd_pkg and tilt_compensated_compass_heading_unit.
module cthd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [79:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import cthd_pkg::*;

    localparam logic [15:0] HEAD_LIMIT = (ANGLE_FRAC_BITS <= 6) ?
        16'(360 << ANGLE_FRAC_BITS) : 16'(1 << HW);

    // a waiting output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // input side stalls exactly while an output beat waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[14:0]} < HEAD_LIMIT)
        else $error("heading out of range");

    a_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[29:15]} < HEAD_LIMIT)
        else $error("tilt heading out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind tilt_compensated_compass_heading_unit cthd_checker u_cthd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_tilt_compensated_compass_heading_unit.sv @@
// Testbench for the tilt-compensated compass heading pipeline.
// Depends on cthd_pkg and tilt_compensated_compass_heading_unit; self-checking.
`timescale 1ns / 100ps

class heading_scoreboard;
    logic [31:0] pending_q[$];
    int          n_errors;
    int          n_checked;

    function new();
        n_errors  = 0;
        n_checked = 0;
    endfunction

    function automatic logic [63:0] sqrt_round(logic [63:0] v);
        logic [63:0] n, r, b;
        n = v; r = 0; b = 64'd1 << 28;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r * r + r < v) r = r + 1;
        return r;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [14:0] heading_of(longint y, longint x);
        longint z, dx, dy, o;
        int     n;
        n = cthd_pkg::CORDIC_N;
        z = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x; y = -y; z = 180 * 65536;
        end
        for (int i = 0; i < n; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y < 0) begin
                x = x - dx; y = y + dy; z = z - longint'(cthd_pkg::atan_q16(i));
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(cthd_pkg::atan_q16(i));
            end
        end
        while (z < 0) z = z + 360 * 65536;
        while (z >= 360 * 65536) z = z - 360 * 65536;
        o = (z + (longint'(1) << (cthd_pkg::RND_SH - 1))) >>> cthd_pkg::RND_SH;
        if (o >= (longint'(360) << cthd_pkg::ANGLE_FRAC_BITS)) o = 0;
        return o[14:0];
    endfunction

    // note an accepted sample and queue its expected heading beat
    function void note_sample(logic [79:0] d);
        longint ax, ay, mx, my, mz, sp, cp, sr, cr, mag, xh, yh;
        logic   clip;
        logic [14:0] h0, h1;
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        mx = longint'($signed(d[47:32]));
        my = longint'($signed(d[63:48]));
        mz = longint'($signed(d[79:64]));
        clip = 1'b0;
        sp = -ax;
        if (sp > 16384) begin sp = 16384; clip = 1'b1; end
        if (sp < -16384) begin sp = -16384; clip = 1'b1; end
        cp = longint'(sqrt_round(64'(longint'(1) << 28) - 64'(sp * sp)));
        mag = (ay < 0) ? -ay : ay;
        if (mag > cp) begin
            sr = 16384; clip = 1'b1;
        end else if (cp == 0) begin
            sr = 0;
        end else begin
            sr = (mag * 16384 + cp / 2) / cp;
            if (sr > 16384) sr = 16384;
        end
        if (ay < 0) sr = -sr;
        cr = longint'(sqrt_round(64'(longint'(1) << 28) - 64'(sr * sr)));
        xh = (mx * cp + mz * sp) * 16384;
        yh = mx * sr * sp + my * cr * 16384 - mz * sr * cp;
        h0 = heading_of(my * (longint'(1) << 24), mx * (longint'(1) << 24));
        h1 = heading_of(yh, xh);
        pending_q.push_back({1'b0, clip, h1, h0});
    endfunction

    function void check_beat(logic [31:0] got);
        logic [31:0] want;
        if (pending_q.size() == 0) begin
            $error("unexpected output beat %h", got);
            n_errors++;
            return;
        end
        want = pending_q.pop_front();
        n_checked++;
        if (got[14:0] !== want[14:0]) begin
            $error("heading_deg: expected %0d, got %0d", want[14:0], got[14:0]);
            n_errors++;
        end
        if (got[29:15] !== want[29:15]) begin
            $error("tilt_heading_deg: expected %0d, got %0d", want[29:15], got[29:15]);
            n_errors++;
        end
        if (got[30] !== want[30]) begin
            $error("tilt_clipped: expected %0b, got %0b", want[30], got[30]);
            n_errors++;
        end
    endfunction
endclass

module tb_tilt_compensated_compass_heading_unit;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // accel_x, accel_y, mag_x, mag_y, mag_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // heading_deg, tilt_heading_deg, tilt_clipped, pad

    heading_scoreboard sb;
    int  n_sent;
    bit  sink_stalls;

    tilt_compensated_compass_heading_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: stall pattern of its own, sometimes long runs with no stall
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!sink_stalls) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
    end

    // present one sample, hold it until accepted
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] mx,
                               logic [15:0] my, logic [15:0] mz);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mz, my, mx, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_accel();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (k < 8) return 16'($urandom);
        return (k == 8) ? 16'sd16384 : -16'sd16384;
    endfunction

    initial begin
        int burst;
        logic [15:0] ax, ay;
        sb = new();
        n_sent = 0;
        sink_stalls = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clipping, vertical pitch, zero vectors, axes
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'hFF00, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_sample(16'h8000, 16'h0000, 16'h1234, 16'h4321, 16'h0100);
        send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h4000, 16'h0000, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'hC000, 16'h0000, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'h4000, 16'h0001, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'h0000, 16'h4000, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'h0000, 16'hC000, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'h0000, 16'h4001, 16'h0100, 16'h0200, 16'h0300);
        send_sample(16'h2000, 16'hE000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF);

        // hold off until the pipeline has drained
        idle_cycles(1);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        sink_stalls = 1'b1;

        while (n_sent < 1870) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                ax = rand_accel();
                ay = rand_accel();
                send_sample(ax, ay, 16'($urandom), 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 7) == 0) sink_stalls = ~sink_stalls;
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (80 + cthd_pkg::CORDIC_N) @(posedge i_clk);
        $display("Sent %0d samples, checked %0d heading beats under random gaps and stalls.",
                 n_sent, sb.n_checked);
        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
